FILE: rtl/core/assert_macros.svh
// assertion macros shared by the scanner rtl
// depends on nothing; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/core/tlvs_pkg.sv
// shared widths, codes and result type of the tlv scanner
// depends on nothing
package tlvs_pkg;

    localparam int DATA_W      = 8;
    localparam int KIND_W      = 2;
    localparam int TAG_IDX_W   = 5;
    localparam int OFFSET_W    = 10;
    localparam int LENGTH_W    = 16;
    localparam int TAG_COUNT_W = 5;
    localparam int TAG_W       = 16;
    localparam int TAG_WORDS   = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_LEFT_W  = 2;
    localparam int MSG_CNT_W   = 2;

    localparam int VALUE_STORE_BYTES_DEF = 1024;
    localparam int MAX_TAGS_DEF          = 28;

    // messages shorter than this are malformed
    localparam logic [MSG_CNT_W-1:0] MIN_MESSAGE_BYTES = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_VALUE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA_ERR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_WORD_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_WORD_LAST  = 3'd7;

    // ber long-form length prefixes
    localparam logic [DATA_W-1:0] LEN_LONG_ONE = 8'h81;
    localparam logic [DATA_W-1:0] LEN_LONG_TWO = 8'h82;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [TAG_IDX_W-1:0] tag_index;
        logic [DATA_W-1:0]    value_byte;
        logic [OFFSET_W-1:0]  value_offset;
        logic [LENGTH_W-1:0]  value_length;
        logic                 last_result;
    } result_t;

endpackage

FILE: rtl/core/tlvs_if.sv
// valid/ready channel interfaces for message bytes and scanner results
// depends on tlvs_pkg
interface tlvs_item_if;
    import tlvs_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface tlvs_result_if;
    import tlvs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [TAG_IDX_W-1:0] tag_index;
    logic [DATA_W-1:0]    value_byte;
    logic [OFFSET_W-1:0]  value_offset;
    logic [LENGTH_W-1:0]  value_length;
    logic                 last_result;

    modport source (output valid, output kind, output tag_index, output value_byte,
                    output value_offset, output value_length, output last_result,
                    input ready);
    modport sink   (input valid, input kind, input tag_index, input value_byte,
                    input value_offset, input value_length, input last_result,
                    output ready);
endinterface

FILE: rtl/core/tag_length_value_scanner_unit.sv
// ber-style tag-length-value scanner, top level
// depends on tlvs_pkg, tlvs_if.sv and assert_macros.svh
// path: a byte enters the input register, is decoded once the result queue has room,
//   and its results go through the result queue onto the result channel
// throughput: one byte per cycle; the four-entry result queue admits a byte only
//   while two entries are free, so a byte stalls while the queue is fuller than that
// reset: rst_n clears tag table, message state, input register and result queue at once
module tag_length_value_scanner_unit #(
    parameter int VALUE_STORE_BYTES = tlvs_pkg::VALUE_STORE_BYTES_DEF,
    parameter int MAX_TAGS          = tlvs_pkg::MAX_TAGS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tlvs_item_if.sink                        item,
    tlvs_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [tlvs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlvs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tlvs_pkg::*;
    `include "assert_macros.svh"

    // store fill can reach the store size itself
    localparam int FILL_W = $clog2(VALUE_STORE_BYTES + 1);
    localparam int SUM_W  = ((FILL_W > LENGTH_W) ? FILL_W : LENGTH_W) + 1;

    // result queue
    localparam int QDEPTH = 4;
    localparam int PTR_W  = 2;
    localparam int CNT_W  = 3;
    localparam logic [CNT_W-1:0] QROOM_LIMIT = CNT_W'(QDEPTH - 2);

    // parse phases
    localparam logic [1:0] PH_SCAN      = 2'd0;
    localparam logic [1:0] PH_LEN_FIRST = 2'd1;
    localparam logic [1:0] PH_LEN_EXT   = 2'd2;
    localparam logic [1:0] PH_VALUE     = 2'd3;

    // configuration registers
    logic [TAG_COUNT_W-1:0] tag_count_reg;
    logic [CFG_DATA_W-1:0]  tag_word_reg [TAG_WORDS];

    // input register
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_byte_reg;
    logic              in_eom_reg;

    // message state
    logic [1:0]            phase_reg,     phase_next;
    logic [DATA_W-1:0]     held_byte_reg, held_byte_next;
    logic                  held_valid_reg, held_valid_next;
    logic [TAG_IDX_W-1:0]  cur_tag_reg,   cur_tag_next;
    logic [LEN_LEFT_W-1:0] len_left_reg,  len_left_next;
    logic [LENGTH_W-1:0]   val_left_reg,  val_left_next;
    logic [LENGTH_W-1:0]   dec_len_reg,   dec_len_next;
    logic [FILL_W-1:0]     fill_reg,      fill_next;
    logic [MAX_TAGS-1:0]   seen_reg,      seen_next;
    logic [MSG_CNT_W-1:0]  msg_cnt_reg,   msg_cnt_next;
    logic                  failed_reg,    failed_next;

    // result queue storage
    result_t           queue_mem [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    // step control
    logic             step;
    logic             pop;
    logic [1:0]       push_cnt;
    result_t          res_a;
    result_t          res_b;

    // tag match outputs
    logic [MAX_TAGS-1:0]  hit_pair;
    logic [MAX_TAGS-1:0]  hit_two;
    logic [MAX_TAGS-1:0]  hit_single;
    logic [MAX_TAGS-1:0]  hit_onehot;
    logic                 hit_found;
    logic                 hit_is_two;
    logic                 hit_seen;
    logic [TAG_IDX_W-1:0] hit_idx;
    logic                 single_any;

    // -------------------------------------------------------------------
    // configuration port
    // -------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_count_reg <= '0;
            for (int w = 0; w < TAG_WORDS; w++)
            begin
                tag_word_reg[w] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAG_COUNT:
                begin
                    tag_count_reg <= cfg_wdata[TAG_COUNT_W-1:0];
                end
                default:
                begin
                    // every other index is a tag word
                    tag_word_reg[CFG_IDX_W'(cfg_index - CFG_TAG_WORD_FIRST)] <= cfg_wdata;
                end
            endcase
        end
    end

    // -------------------------------------------------------------------
    // input register: parts the byte channel from the decode stage
    // -------------------------------------------------------------------
    // the decode stage fires when two queue slots are free
    assign step       = in_valid_reg && (count_reg <= QROOM_LIMIT);
    assign item.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
            in_eom_reg   <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= item.data_byte;
                in_eom_reg   <= item.end_of_message;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------------------
    // tag table compare, all entries in parallel
    // pair match: held byte is a one-byte tag, or held and current bytes form a two-byte tag
    // single match: current byte alone is a one-byte tag (end-of-message check)
    // -------------------------------------------------------------------
    always_comb
    begin
        logic [TAG_W-1:0]  ent;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        logic              en;
        for (int i = 0; i < MAX_TAGS; i++)
        begin
            ent = tag_word_reg[CFG_IDX_W'(i >> 2)][(i & 3) * TAG_W +: TAG_W];
            hi  = ent[TAG_W-1:DATA_W];
            lo  = ent[DATA_W-1:0];
            // entries at or beyond tag_count are off; an empty first byte never matches
            en  = (TAG_COUNT_W'(i) < tag_count_reg) && (hi != '0);
            hit_pair[i]   = en && (hi == held_byte_reg) && ((lo == '0) || (lo == in_byte_reg));
            hit_two[i]    = (lo != '0);
            hit_single[i] = en && (lo == '0) && (hi == in_byte_reg);
        end
    end

    // first match in table order wins
    always_comb
    begin
        hit_found  = 1'b0;
        hit_is_two = 1'b0;
        hit_seen   = 1'b0;
        hit_idx    = '0;
        hit_onehot = '0;
        for (int i = MAX_TAGS - 1; i >= 0; i--)
        begin
            if (hit_pair[i])
            begin
                hit_found     = 1'b1;
                hit_is_two    = hit_two[i];
                hit_seen      = seen_reg[i];
                hit_idx       = TAG_IDX_W'(i);
                hit_onehot    = '0;
                hit_onehot[i] = 1'b1;
            end
        end
    end

    assign single_any = |hit_single;

    // -------------------------------------------------------------------
    // decode step: next message state and up to two results
    // -------------------------------------------------------------------
    always_comb
    begin
        logic                  do_len;
        logic                  len_first;
        logic                  len_done;
        logic                  body_v;
        logic                  eom_v;
        logic [LEN_LEFT_W-1:0] len_left_dec;
        logic [LENGTH_W-1:0]   val_left_dec;
        logic [MSG_CNT_W-1:0]  msg_cnt_inc;
        result_t               body;
        result_t               eom_res;

        phase_next      = phase_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        cur_tag_next    = cur_tag_reg;
        len_left_next   = len_left_reg;
        val_left_next   = val_left_reg;
        dec_len_next    = dec_len_reg;
        fill_next       = fill_reg;
        seen_next       = seen_reg;
        failed_next     = failed_reg;

        do_len       = 1'b0;
        len_first    = 1'b1;
        len_done     = 1'b0;
        body_v       = 1'b0;
        eom_v        = 1'b0;
        len_left_dec = '0;
        val_left_dec = '0;
        body         = '0;
        eom_res      = '0;

        // byte count of the message, saturating at the minimum length
        msg_cnt_inc = (msg_cnt_reg < MIN_MESSAGE_BYTES) ? MSG_CNT_W'(msg_cnt_reg + 1'b1)
                                                        : msg_cnt_reg;

        if (!failed_reg)
        begin
            case (phase_reg)
                PH_SCAN:
                begin
                    if (!held_valid_reg)
                    begin
                        held_byte_next  = in_byte_reg;
                        held_valid_next = 1'b1;
                    end
                    else if (!hit_found)
                    begin
                        // skip the held byte, the current one may start a tag
                        held_byte_next = in_byte_reg;
                    end
                    else
                    begin
                        held_valid_next = 1'b0;
                        if (hit_seen)
                        begin
                            body_v      = 1'b1;
                            body.kind   = KIND_DATA_ERR;
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            seen_next    = seen_reg | hit_onehot;
                            cur_tag_next = hit_idx;
                            phase_next   = PH_LEN_FIRST;
                            // one-byte tag: the current byte is already the length
                            do_len       = !hit_is_two;
                        end
                    end
                end
                PH_LEN_FIRST:
                begin
                    do_len = 1'b1;
                end
                PH_LEN_EXT:
                begin
                    do_len    = 1'b1;
                    len_first = 1'b0;
                end
                PH_VALUE:
                begin
                    body_v            = 1'b1;
                    body.kind         = KIND_VALUE;
                    body.tag_index    = cur_tag_reg;
                    body.value_byte   = in_byte_reg;
                    body.value_offset = OFFSET_W'(fill_reg);
                    body.value_length = dec_len_reg;
                    fill_next         = FILL_W'(fill_reg + 1'b1);
                    val_left_dec      = (val_left_reg != '0) ? LENGTH_W'(val_left_reg - 1'b1)
                                                             : val_left_reg;
                    val_left_next     = val_left_dec;
                    if (val_left_dec == '0)
                    begin
                        phase_next = PH_SCAN;
                    end
                end
                default:
                begin
                    phase_next = PH_SCAN;
                end
            endcase
        end

        // ber length byte
        if (do_len)
        begin
            if (len_first)
            begin
                if (!in_byte_reg[DATA_W-1])
                begin
                    // short form
                    dec_len_next = LENGTH_W'(in_byte_reg);
                    len_done     = 1'b1;
                end
                else if ((in_byte_reg == LEN_LONG_ONE) || (in_byte_reg == LEN_LONG_TWO))
                begin
                    dec_len_next  = '0;
                    len_left_next = in_byte_reg[LEN_LEFT_W-1:0];
                    phase_next    = PH_LEN_EXT;
                end
                else
                begin
                    body_v      = 1'b1;
                    body.kind   = KIND_DATA_ERR;
                    failed_next = 1'b1;
                end
            end
            else
            begin
                dec_len_next  = {dec_len_reg[LENGTH_W-DATA_W-1:0], in_byte_reg};
                len_left_dec  = (len_left_reg != '0) ? LEN_LEFT_W'(len_left_reg - 1'b1)
                                                     : len_left_reg;
                len_left_next = len_left_dec;
                len_done      = (len_left_dec == '0);
            end
        end

        // length complete: check room in the value store
        if (len_done)
        begin
            if ((SUM_W'(fill_reg) + SUM_W'(dec_len_next)) > SUM_W'(VALUE_STORE_BYTES))
            begin
                body_v      = 1'b1;
                body.kind   = KIND_OVERFLOW;
                failed_next = 1'b1;
            end
            else if (dec_len_next == '0)
            begin
                phase_next = PH_SCAN;
            end
            else
            begin
                val_left_next = dec_len_next;
                phase_next    = PH_VALUE;
            end
        end

        // end of message: report once unless the message has failed, then clear
        msg_cnt_next = msg_cnt_inc;
        if (in_eom_reg)
        begin
            if (!failed_next)
            begin
                eom_v = 1'b1;
                // a held byte is always the current byte here
                if ((msg_cnt_inc < MIN_MESSAGE_BYTES) || (phase_next != PH_SCAN) ||
                    (held_valid_next && single_any))
                begin
                    eom_res.kind = KIND_DATA_ERR;
                end
                else
                begin
                    eom_res.kind = KIND_DONE;
                end
            end
            phase_next      = PH_SCAN;
            held_byte_next  = '0;
            held_valid_next = 1'b0;
            cur_tag_next    = '0;
            len_left_next   = '0;
            val_left_next   = '0;
            dec_len_next    = '0;
            fill_next       = '0;
            seen_next       = '0;
            msg_cnt_next    = '0;
            failed_next     = 1'b0;
        end

        // order the results: body result first, end-of-message result last
        eom_res.last_result = 1'b1;
        body.last_result    = !eom_v;
        res_a    = body_v ? body : eom_res;
        res_b    = eom_res;
        push_cnt = {1'b0, body_v} + {1'b0, eom_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SCAN;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            cur_tag_reg    <= '0;
            len_left_reg   <= '0;
            val_left_reg   <= '0;
            dec_len_reg    <= '0;
            fill_reg       <= '0;
            seen_reg       <= '0;
            msg_cnt_reg    <= '0;
            failed_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            cur_tag_reg    <= cur_tag_next;
            len_left_reg   <= len_left_next;
            val_left_reg   <= val_left_next;
            dec_len_reg    <= dec_len_next;
            fill_reg       <= fill_next;
            seen_reg       <= seen_next;
            msg_cnt_reg    <= msg_cnt_next;
            failed_reg     <= failed_next;
        end
    end

    // -------------------------------------------------------------------
    // result queue: takes up to two results per step, hands out one per transaction
    // -------------------------------------------------------------------
    assign pop = result.valid && result.ready;

    always_ff @(posedge clk)
    begin
        if (step && (push_cnt != 2'd0))
        begin
            queue_mem[wr_ptr_reg] <= res_a;
        end
        if (step && (push_cnt == 2'd2))
        begin
            queue_mem[PTR_W'(wr_ptr_reg + 1'b1)] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (step)
            begin
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + push_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + 1'b1);
            end
            count_reg <= CNT_W'(count_reg + (step ? CNT_W'(push_cnt) : CNT_W'(0))
                                - (pop ? CNT_W'(1) : CNT_W'(0)));
        end
    end

    assign result.valid        = (count_reg != '0);
    assign result.kind         = queue_mem[rd_ptr_reg].kind;
    assign result.tag_index    = queue_mem[rd_ptr_reg].tag_index;
    assign result.value_byte   = queue_mem[rd_ptr_reg].value_byte;
    assign result.value_offset = queue_mem[rd_ptr_reg].value_offset;
    assign result.value_length = queue_mem[rd_ptr_reg].value_length;
    assign result.last_result  = queue_mem[rd_ptr_reg].last_result;

    // -------------------------------------------------------------------
    // assertions
    // -------------------------------------------------------------------
    `ASSERT_NEVER(a_queue_bound, clk, rst_n, count_reg > CNT_W'(QDEPTH),
                  "result queue holds more entries than it has")
    `ASSERT_CLK(a_quiet_after_fail, clk, rst_n, (step && failed_reg) |-> (push_cnt == 2'd0),
                "results produced after an error in the same message")
    `ASSERT_CLK(a_value_count, clk, rst_n, (phase_reg == PH_VALUE) |-> (val_left_reg != '0),
                "value phase with no value bytes left")
    `ASSERT_NEVER(a_store_bound, clk, rst_n, SUM_W'(fill_reg) > SUM_W'(VALUE_STORE_BYTES),
                  "value store fill beyond the store size")

endmodule
